>>> rtl/lcps_pkg.sv
// lcps_pkg: shared constants for the led cube plane sweep
// no dependencies; used by the channel interfaces and the top level

package lcps_pkg;

   localparam int CUBE_SIZE = 8;
   localparam int BYTE_W    = 8;
   localparam int COLS_W    = CUBE_SIZE * BYTE_W;
   localparam int NOW_W     = 32;
   localparam int PERIOD_W  = 16;
   localparam int POS_W     = $clog2(CUBE_SIZE);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

   localparam logic [BYTE_W-1:0] ALL_LAYERS = 8'hff;
   localparam logic [BYTE_W-1:0] TOP_BIT    = 8'h80;
   localparam logic [BYTE_W-1:0] LOW_BIT    = 8'h01;

   localparam logic OP_POLL    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

endpackage

>>> rtl/lcps_req_if.sv
// lcps_req_if: input channel, poll time or restart command
// depends on lcps_pkg

interface lcps_req_if;
   import lcps_pkg::*;

   logic             valid;
   logic             ready;
   logic             op;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, output op, output now_ms, input ready);
   modport sink   (input valid, input op, input now_ms, output ready);
endinterface

>>> rtl/lcps_rsp_if.sv
// lcps_rsp_if: result channel, one cube frame per transfer
// depends on lcps_pkg

interface lcps_rsp_if;
   import lcps_pkg::*;

   logic              valid;
   logic              ready;
   logic [COLS_W-1:0] column_bytes;
   logic [BYTE_W-1:0] layer_mask;

   modport source (output valid, output column_bytes, output layer_mask, input ready);
   modport sink   (input valid, input column_bytes, input layer_mask, output ready);
endinterface

>>> rtl/lcps_csr_if.sv
// lcps_csr_if: configuration write channel for the step period
// depends on lcps_pkg

interface lcps_csr_if;
   import lcps_pkg::*;

   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] step_period_ms;

   modport source (output valid, output step_period_ms, input ready);
   modport sink   (input valid, input step_period_ms, output ready);
endinterface

>>> rtl/led_cube_plane_sweep.sv
// led_cube_plane_sweep: frame generator sweeping a lit plane along x, y and z
// depends on lcps_pkg, lcps_req_if, lcps_rsp_if, lcps_csr_if
//
// One request is taken per clock cycle. Each poll compares the elapsed time
// (wrapping 32-bit subtract) with the step period and updates the sweep state
// in the cycle of its transfer; a frame, if any, appears in the result register
// on the next cycle. A new request is taken in the same cycle that a waiting
// frame is transferred, so the rate is one request per cycle as long as frames
// are taken; while a frame waits on a stalled result channel no request is
// taken. A restart returns the sweep to the x phase without touching the frame
// timer.

module led_cube_plane_sweep (
   input logic       clock,
   input logic       reset,
   lcps_req_if.sink  req_chan,
   lcps_rsp_if.source rsp_chan,
   lcps_csr_if.sink  csr_chan
);
   import lcps_pkg::*;

   typedef enum logic [1:0] {
      PHASE_X    = 2'd0,
      PHASE_Y    = 2'd1,
      PHASE_Z    = 2'd2,
      PHASE_IDLE = 2'd3
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic                fwd_ff, fwd_in;
   logic [POS_W-1:0]    xpos_ff, xpos_in;
   logic [NOW_W-1:0]    last_ff, last_in;
   logic [BYTE_W-1:0]   ypat_ff, ypat_in;
   logic [BYTE_W-1:0]   lpat_ff, lpat_in;
   logic [PERIOD_W-1:0] period_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLS_W-1:0]   cols_ff, cols_in;
   logic [BYTE_W-1:0]   mask_ff, mask_in;

   logic                accept;
   logic                due;
   logic                emit;
   logic [NOW_W-1:0]    elapsed;
   logic [POS_W-1:0]    xsel;
   logic [BYTE_W-1:0]   shifted;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign elapsed = req_chan.now_ms - last_ff;
   assign due     = elapsed >= NOW_W'(period_ff);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.column_bytes = cols_ff;
   assign rsp_chan.layer_mask   = mask_ff;

   always_comb begin
      phase_in = phase_ff;
      fwd_in   = fwd_ff;
      xpos_in  = xpos_ff;
      last_in  = last_ff;
      ypat_in  = ypat_ff;
      lpat_in  = lpat_ff;
      emit     = 1'b0;
      cols_in  = cols_ff;
      mask_in  = mask_ff;
      xsel     = xpos_ff;
      shifted  = '0;

      if (accept) begin
         if (req_chan.op == OP_RESTART) begin
            phase_in = PHASE_X;
            fwd_in   = 1'b1;
            xpos_in  = '0;
            ypat_in  = '0;
            lpat_in  = '0;
         end else begin
            unique case (phase_ff)
               PHASE_X: begin
                  lpat_in = ALL_LAYERS;
                  if (due) begin
                     emit    = 1'b1;
                     last_in = req_chan.now_ms;
                     mask_in = ALL_LAYERS;
                     if (fwd_ff) begin
                        xsel = xpos_ff;
                        if (xpos_ff == POS_W'(CUBE_SIZE - 1)) fwd_in = 1'b0;
                        else xpos_in = xpos_ff + 1'b1;
                     end else begin
                        xsel    = xpos_ff - 1'b1;
                        xpos_in = xsel;
                        if (xsel == '0) begin
                           fwd_in   = 1'b1;
                           phase_in = PHASE_Y;
                        end
                     end
                     for (int j = 0; j < CUBE_SIZE; j++) begin
                        cols_in[j*BYTE_W +: BYTE_W] =
                           (xsel == POS_W'(j)) ? ALL_LAYERS : '0;
                     end
                  end
               end
               PHASE_Y: begin
                  lpat_in = ALL_LAYERS;
                  mask_in = ALL_LAYERS;
                  if (ypat_ff == '0) begin
                     emit    = 1'b1;
                     ypat_in = LOW_BIT;
                     last_in = req_chan.now_ms;
                     cols_in = {CUBE_SIZE{LOW_BIT}};
                  end else if (due) begin
                     emit    = 1'b1;
                     last_in = req_chan.now_ms;
                     if (fwd_ff) begin
                        shifted = ypat_ff << 1;
                        if (shifted == TOP_BIT) fwd_in = 1'b0;
                     end else begin
                        shifted = ypat_ff >> 1;
                        if (shifted == '0) begin
                           lpat_in  = '0;
                           fwd_in   = 1'b1;
                           phase_in = PHASE_Z;
                        end
                     end
                     ypat_in = shifted;
                     cols_in = {CUBE_SIZE{shifted}};
                  end
               end
               PHASE_Z: begin
                  cols_in = '1;
                  if (lpat_ff == '0) begin
                     emit    = 1'b1;
                     lpat_in = LOW_BIT;
                     last_in = req_chan.now_ms;
                     mask_in = LOW_BIT;
                  end else if (due) begin
                     emit    = 1'b1;
                     last_in = req_chan.now_ms;
                     if (fwd_ff) begin
                        shifted = lpat_ff << 1;
                        lpat_in = shifted;
                        if (shifted == TOP_BIT) fwd_in = 1'b0;
                     end else begin
                        shifted = lpat_ff >> 1;
                        lpat_in = shifted;
                        if (shifted == LOW_BIT) begin
                           xpos_in  = '0;
                           fwd_in   = 1'b1;
                           phase_in = PHASE_X;
                           lpat_in  = '0;
                        end
                     end
                     mask_in = shifted;
                  end
               end
               PHASE_IDLE: begin
                  emit = 1'b0;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end
      end

      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_X;
         fwd_ff       <= 1'b1;
         xpos_ff      <= '0;
         last_ff      <= '0;
         ypat_ff      <= '0;
         lpat_ff      <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fwd_ff       <= fwd_in;
         xpos_ff      <= xpos_in;
         last_ff      <= last_in;
         ypat_ff      <= ypat_in;
         lpat_ff      <= lpat_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            period_ff <= csr_chan.step_period_ms;
         end
      end
   end

   // frame payload, loaded only on a new frame
   always_ff @(posedge clock) begin
      if (emit) begin
         cols_ff <= cols_in;
         mask_ff <= mask_in;
      end
   end

endmodule
